/* sv/itoa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the integer to ASCII converter modules.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned REQ_BITS   = 3;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CHAR_BITS  = 8;

  // Request type codes.
  localparam logic [REQ_BITS-1:0] REQ_UDEC = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_UHEX = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_UBIN = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_SDEC = 3'd3;
  localparam logic [REQ_BITS-1:0] REQ_SHEX = 3'd4;
  localparam logic [REQ_BITS-1:0] REQ_SBIN = 3'd5;

  // Character codes.
  localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_PLUS  = 8'h2B;

  typedef struct packed {
    logic [REQ_BITS-1:0]   req_type;
    logic [VALUE_BITS-1:0] value;
  } itoa_in_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
  } itoa_out_t;

  typedef enum logic [1:0] {
    RADIX_DEC,
    RADIX_HEX,
    RADIX_BIN
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic dabble;
    logic emit_sign;
    logic skip;
    logic emit_digit;
  } itoa_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_ok;
    logic req_dec;
    logic req_signed;
    logic is_signed;
    logic dabble_last;
    logic lead_zero;
    logic last_digit;
  } itoa_sts_t;

endpackage

/* sv/itoa_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer for one conversion: decimal binary-to-BCD steps, sign character,
// leading-zero skip and digit emission.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  itoa_pkg::itoa_sts_t sts,
  output itoa_pkg::itoa_cmd_t cmd,
  output logic                busy
);
  import itoa_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        // Undefined request types are taken and dropped without output.
        if (start && sts.req_ok) begin
          if (sts.req_dec) begin
            state_nxt = ST_DABBLE;
          end else if (sts.req_signed) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_DABBLE: begin
        if (sts.dabble_last) begin
          state_nxt = sts.is_signed ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        if (!sts.lead_zero || sts.last_digit) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.last_digit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && sts.req_ok;
      end
      ST_DABBLE: begin
        cmd.dabble = 1'b1;
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
      end
      ST_SKIP: begin
        cmd.skip = sts.lead_zero && !sts.last_digit;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule

/* sv/itoa_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_datapath
// Magnitude and BCD shift registers, digit counters and the output register.
// ----------------------------------------------------------------------------
module itoa_datapath #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  itoa_pkg::itoa_in_t  in_word,
  input  itoa_pkg::itoa_cmd_t cmd,
  output itoa_pkg::itoa_sts_t sts,
  output itoa_pkg::itoa_out_t out_word,
  output logic                out_valid
);
  import itoa_pkg::*;

  localparam int unsigned HD = (WORD_BITS + 3) / 4;
  localparam int unsigned HW = HD * 4;
  // Decimal digits of the largest unsigned word (log10 of 2 scaled).
  localparam int unsigned ND = (WORD_BITS * 30103) / 100000 + 1;
  localparam int unsigned BW = ND * 4;
  localparam int unsigned CW = $clog2(WORD_BITS + 1);

  logic [HW-1:0]        mag_r, mag_nxt;
  logic [BW-1:0]        bcd_r, bcd_nxt;
  logic [BW-1:0]        bcd_adj;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic [CW-1:0]        dcnt_r, dcnt_nxt;
  radix_t               radix_r, radix_nxt;
  radix_t               in_radix;
  logic                 signed_r, signed_nxt;
  logic                 neg_r, neg_nxt;
  logic                 in_signed;
  logic                 in_neg;
  logic [63:0]          value_ext;
  logic [WORD_BITS-1:0] in_v;
  logic [WORD_BITS-1:0] in_mag;
  logic [3:0]           top_digit;
  logic [CHAR_BITS-1:0] digit_char;
  itoa_out_t            out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Request decode straight from the input word.
  always_comb begin
    in_radix = RADIX_BIN;
    case (in_word.req_type) inside
      REQ_UDEC, REQ_SDEC: in_radix = RADIX_DEC;
      REQ_UHEX, REQ_SHEX: in_radix = RADIX_HEX;
      default:            in_radix = RADIX_BIN;
    endcase
  end

  assign in_signed = (in_word.req_type == REQ_SDEC) || (in_word.req_type == REQ_SHEX) ||
                     (in_word.req_type == REQ_SBIN);
  assign value_ext = 64'(in_word.value);
  assign in_v      = value_ext[WORD_BITS-1:0];
  assign in_neg    = in_signed && in_v[WORD_BITS-1];
  // The most negative word negates to itself, which read unsigned is its magnitude.
  assign in_mag    = in_neg ? WORD_BITS'(~in_v + WORD_BITS'(1)) : in_v;

  always_comb begin
    top_digit = {3'b000, mag_r[WORD_BITS-1]};
    case (radix_r)
      RADIX_DEC: top_digit = bcd_r[BW-1 -: 4];
      RADIX_HEX: top_digit = mag_r[HW-1 -: 4];
      default:   top_digit = {3'b000, mag_r[WORD_BITS-1]};
    endcase
  end

  assign digit_char = {4'b0000, top_digit} +
                      ((top_digit > 4'd9) ? (CH_A - 8'd10) : CH_ZERO);

  always_comb begin
    for (int k = 0; k < ND; k++) begin
      if (bcd_r[k*4 +: 4] >= 4'd5) begin
        bcd_adj[k*4 +: 4] = bcd_r[k*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[k*4 +: 4] = bcd_r[k*4 +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    dcnt_nxt      = dcnt_r;
    radix_nxt     = radix_r;
    signed_nxt    = signed_r;
    neg_nxt       = neg_r;
    out_nxt       = out_r;
    out_valid_nxt = 1'b0;
    if (cmd.load) begin
      mag_nxt    = HW'(in_mag);
      bcd_nxt    = '0;
      dcnt_nxt   = CW'(WORD_BITS);
      radix_nxt  = in_radix;
      signed_nxt = in_signed;
      neg_nxt    = in_neg;
      case (in_radix)
        RADIX_DEC: cnt_nxt = CW'(ND);
        RADIX_HEX: cnt_nxt = CW'(HD);
        default:   cnt_nxt = CW'(WORD_BITS);
      endcase
    end
    if (cmd.dabble) begin
      bcd_nxt  = {bcd_adj[BW-2:0], mag_r[WORD_BITS-1]};
      mag_nxt  = mag_r << 1;
      dcnt_nxt = dcnt_r - CW'(1);
    end
    if (cmd.emit_sign) begin
      out_nxt.char_code = neg_r ? CH_MINUS : CH_PLUS;
      out_nxt.last_char = 1'b0;
      out_valid_nxt     = 1'b1;
    end
    if (cmd.emit_digit) begin
      out_nxt.char_code = digit_char;
      out_nxt.last_char = (cnt_r == CW'(1));
      out_valid_nxt     = 1'b1;
    end
    if (cmd.skip || cmd.emit_digit) begin
      cnt_nxt = cnt_r - CW'(1);
      case (radix_r)
        RADIX_DEC: bcd_nxt = bcd_r << 4;
        RADIX_HEX: mag_nxt = mag_r << 4;
        default:   mag_nxt = mag_r << 1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r    <= mag_nxt;
    bcd_r    <= bcd_nxt;
    cnt_r    <= cnt_nxt;
    dcnt_r   <= dcnt_nxt;
    radix_r  <= radix_nxt;
    signed_r <= signed_nxt;
    neg_r    <= neg_nxt;
    out_r    <= out_nxt;
  end

  always_comb begin
    sts.req_ok      = (in_word.req_type <= REQ_SBIN);
    sts.req_dec     = (in_radix == RADIX_DEC);
    sts.req_signed  = in_signed;
    sts.is_signed   = signed_r;
    sts.dabble_last = (dcnt_r == CW'(1));
    sts.lead_zero   = (top_digit == 4'd0);
    sts.last_digit  = (cnt_r == CW'(1));
  end

  assign out_word  = out_r;
  assign out_valid = out_valid_r;

endmodule

/* sv/integer_to_ascii_radix.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts one integer word to ASCII characters in decimal, hex or binary.
// ----------------------------------------------------------------------------
// Busy is high through a conversion: BCD steps for decimal, the sign for signed
// requests, leading-zero skip and emission over the digit capacity (decimal
// digits, nibbles or bits of the word); the next word is taken as soon as busy
// falls. The sign leaves first for signed requests (after the BCD steps for
// decimal); digits then follow one per cycle once leading zeros are skipped.
// The receiver cannot stall. Reset clears the sequencer and the output strobe.
module integer_to_ascii_radix #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  itoa_pkg::itoa_in_t  in_word,
  output logic                out_valid,
  output itoa_pkg::itoa_out_t out_word
);
  import itoa_pkg::*;

  itoa_cmd_t cmd;
  itoa_sts_t sts;

  itoa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  itoa_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word),
    .out_valid (out_valid)
  );

endmodule
